/* rtl/core/tms_pkg.sv */
package tms_pkg;

  localparam int TAPE_CELLS  = 4096;
  localparam int TAPE_GUARD  = 16;
  localparam int MAX_SYMBOLS = 16;
  localparam int MAX_STATES  = 64;

  typedef enum logic [2:0] {
    ACT_STEP   = 3'd0,
    ACT_RULE   = 3'd1,
    ACT_APPEND = 3'd2,
    ACT_CLEAR  = 3'd3,
    ACT_EVAL   = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    ST_DONE    = 3'd0,
    ST_LIMIT   = 3'd1,
    ST_EDGE    = 3'd2,
    ST_HALTED  = 3'd3,
    ST_IGNORED = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    MV_LEFT  = 2'd0,
    MV_RIGHT = 2'd1,
    MV_STAY  = 2'd2,
    MV_HALT  = 2'd3
  } move_t;

  typedef enum logic [2:0] {
    CFG_MAX_TIME  = 3'd0,
    CFG_MAX_AMP   = 3'd1,
    CFG_MAX_SHARE = 3'd2,
    CFG_ALPHABET  = 3'd3,
    CFG_INIT_ST   = 3'd4
  } cfg_index_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_STEP_RD,
    S_STEP_WAIT,
    S_STEP_EXEC,
    S_CLEAR,
    S_EVAL_CLR,
    S_EVAL_SCAN,
    S_EVAL_MAX,
    S_EVAL_MUL,
    S_EVAL_CMP,
    S_OUT
  } fsm_t;

endpackage

/* rtl/core/tms_if.sv */
interface tms_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [3:0]  read_symbol;
  logic [5:0]  rule_state;
  logic [3:0]  write_symbol;
  logic [1:0]  move_code;
  logic [5:0]  next_state;
  logic [7:0]  tape_symbol;
  logic [12:0] amplitude;
  modport source (output valid, action, read_symbol, rule_state, write_symbol,
                  move_code, next_state, tape_symbol, amplitude, input ready);
  modport sink (input valid, action, read_symbol, rule_state, write_symbol,
                move_code, next_state, tape_symbol, amplitude, output ready);
endinterface

interface tms_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        keep_going;
  logic [5:0]  head_state;
  logic [11:0] head_position;
  logic [11:0] step_count;
  logic [11:0] tape_amplitude;
  modport source (output valid, status, keep_going, head_state, head_position,
                  step_count, tape_amplitude, input ready);
  modport sink (input valid, status, keep_going, head_state, head_position,
                step_count, tape_amplitude, output ready);
endinterface

/* rtl/core/turing_machine_stepper_core.sv */
// Turing machine stepper core.
// Input channel (in): one beat carries an action (step, write rule, append
// tape symbol, clear tape, evaluate spread) with its operand fields. Output
// channel (out): exactly one result beat per input beat, giving a status, the
// evaluate verdict and the current state, head position, step count and span.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data); the user
// must see that it is written only while the core is idle, which the core
// does not enforce. Step limit changes move the start position and guard
// span at the next clear. One item is handled at a time; ready is low from
// acceptance until the result beat has been taken. A rule write or an
// undefined action goes straight to the result; an append passes the execute
// state first. A step reads the tape at acceptance, then the rule, waits in a
// settling state, then executes and writes the tape back through the single
// port. Clear sweeps the whole tape, one cell a cycle. Evaluate walks the span
// one cell a cycle through the tape read port, scans the counters of the
// symbols in use, multiplies once and compares.
// After reset the core runs a clearing pass over the tape memory before it
// accepts the first item; configuration writes are taken during that pass.
// A stalled receiver simply holds the result register and the core waits
// with ready low.
module turing_machine_stepper_core
  import tms_pkg::*;
#(
  parameter int TapeGuard  = TAPE_GUARD
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_data,
  tms_in_if.sink      in,
  tms_out_if.source   out
);

  localparam int TapeCells  = TAPE_CELLS;
  localparam int MaxSymbols = MAX_SYMBOLS;
  localparam int MaxStates  = MAX_STATES;
  localparam int TW = $clog2(TapeCells);
  localparam int SW = (MaxSymbols > 1) ? $clog2(MaxSymbols) : 1;
  localparam int QW = (MaxStates > 1) ? $clog2(MaxStates) : 1;
  localparam int RW = SW + QW;
  localparam int CW = TW + 1;

  // Configuration registers.
  logic [10:0] time_limit;
  logic [11:0] span_limit;
  logic [16:0] max_share;
  logic [4:0]  symbol_limit;
  logic [5:0]  start_state;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_limit   <= 11'd1000;
      span_limit   <= 12'd4095;
      max_share    <= 17'd65536;
      symbol_limit <= 5'd2;
      start_state  <= 6'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_TIME:  time_limit   <= cfg_data[10:0];
        CFG_MAX_AMP:   span_limit   <= cfg_data[11:0];
        CFG_MAX_SHARE: max_share    <= cfg_data;
        CFG_ALPHABET:  symbol_limit <= cfg_data[4:0];
        CFG_INIT_ST:   start_state  <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // Memories. Rule entry: write symbol, move, next state.
  logic [SW+2+QW-1:0] rule_mem [2**RW];
  logic [SW-1:0]      tape_mem [TapeCells];
  logic [SW+2+QW-1:0] rule_rd;
  logic [SW-1:0]      tape_rd;
  logic               rule_we;
  logic [RW-1:0]      rule_wa;
  logic [RW-1:0]      rule_ra;
  logic [SW+2+QW-1:0] rule_wd;
  logic               tape_we;
  logic [TW-1:0]      tape_addr;
  logic [SW-1:0]      tape_wd;

  always_ff @(posedge clk) begin
    if (rule_we) rule_mem[rule_wa] <= rule_wd;
    rule_rd <= rule_mem[rule_ra];
  end

  always_ff @(posedge clk) begin
    if (tape_we) tape_mem[tape_addr] <= tape_wd;
    tape_rd <= tape_mem[tape_addr];
  end

  // Symbol histogram for evaluate.
  logic [CW-1:0] counts [MaxSymbols];

  fsm_t          state, state_next;
  logic [CW-1:0] sweep;
  logic [TW-1:0] head_pos;
  logic [TW:0]   span_low, span_high;
  logic [11:0]   steps;
  logic [5:0]    mstate;
  logic [2:0]    r_status;
  logic          r_keep;
  logic [CW-1:0] best;
  logic [8:0]    sym_i;
  logic [12:0]   amp_q;
  logic [29:0]   prod;

  // Reload values used at clear and reset.
  logic [11:0] start_head;
  logic [12:0] guard_lo, guard_hi;
  logic [12:0] edge_full;
  logic [TW:0] tape_edge;
  assign start_head = {1'b0, time_limit} + 12'd1;
  assign guard_lo   = ({1'b0, start_head} >= 13'(TapeGuard))
                      ? {1'b0, start_head} - 13'(TapeGuard) : 13'd0;
  assign guard_hi   = {1'b0, start_head} + 13'(TapeGuard);
  assign edge_full  = {1'b0, time_limit, 1'b0} + 13'd1;
  assign tape_edge  = (edge_full > 13'(TapeCells - 1)) ? (TW+1)'(TapeCells - 1)
                      : (TW+1)'(edge_full);

  logic [TW+1:0] amp_now;
  assign amp_now = {1'b0, span_high} - {1'b0, span_low} + 1'b1;

  logic [4:0] n_sym;
  assign n_sym = (symbol_limit < 5'(MaxSymbols > 16 ? 16 : MaxSymbols))
                 ? symbol_limit : 5'(MaxSymbols > 16 ? 16 : MaxSymbols);

  // Decoded rule read.
  logic [SW-1:0] rule_wsym;
  logic [1:0]    rule_mv;
  logic [QW-1:0] rule_nxt;
  assign {rule_wsym, rule_mv, rule_nxt} = rule_rd;

  logic [TW-1:0] head_moved;
  always_comb begin
    case (move_t'(rule_mv))
      MV_LEFT:  head_moved = head_pos - 1'b1;
      MV_RIGHT: head_moved = head_pos + 1'b1;
      default:  head_moved = head_pos;
    endcase
  end

  // Items latched at acceptance.
  logic [2:0]  act;
  logic [7:0]  tsym_q;

  assign in.ready  = (state == S_IDLE);
  assign out.valid = (state == S_OUT);
  assign out.status         = r_status;
  assign out.keep_going     = r_keep;
  assign out.head_state     = mstate;
  assign out.head_position  = 12'(head_pos);
  assign out.step_count     = steps;
  assign out.tape_amplitude = (amp_now > (TW+2)'(4095)) ? 12'd4095 : 12'(amp_now);

  // Memory ports and next state.
  always_comb begin
    state_next = state;
    rule_we    = 1'b0;
    rule_wa    = {in.read_symbol[SW-1:0], in.rule_state[QW-1:0]};
    rule_wd    = {in.write_symbol[SW-1:0], in.move_code, in.next_state[QW-1:0]};
    rule_ra    = {tape_rd, mstate[QW-1:0]};
    tape_we    = 1'b0;
    tape_addr  = head_pos;
    tape_wd    = rule_wsym;
    case (state)
      S_CLEAR: begin
        tape_we   = 1'b1;
        tape_addr = sweep[TW-1:0];
        tape_wd   = '0;
        // The pass after reset has no item behind it and returns to idle.
        if (sweep == CW'(TapeCells - 1))
          state_next = (act == ACT_CLEAR) ? S_OUT : S_IDLE;
      end
      S_IDLE: begin
        if (in.valid) begin
          case (action_t'(in.action))
            ACT_STEP: state_next = S_STEP_RD;
            ACT_RULE: begin
              rule_we = (32'(in.read_symbol) < MaxSymbols) &&
                        (32'(in.rule_state) < MaxStates);
              state_next = S_OUT;
            end
            ACT_APPEND: state_next = S_STEP_EXEC;
            ACT_CLEAR:  state_next = S_CLEAR;
            ACT_EVAL:   state_next = S_EVAL_CLR;
            default:    state_next = S_OUT;
          endcase
        end
      end
      S_STEP_RD:   state_next = S_STEP_WAIT;
      S_STEP_WAIT: state_next = S_STEP_EXEC;
      S_STEP_EXEC: begin
        if (act == ACT_APPEND) begin
          tape_addr = head_pos + 1'b1;
          tape_wd   = tsym_q[SW-1:0];
          tape_we   = !(9'(tsym_q) >= 9'(n_sym)) &&
                      !({1'b0, head_pos} >= tape_edge);
        end else begin
          tape_we = !((steps > 12'(time_limit)) ||
                      ((TW+2)'(span_limit) < amp_now)) &&
                    !((head_pos == '0) || ({1'b0, head_pos} >= tape_edge));
        end
        state_next = S_OUT;
      end
      S_EVAL_CLR: begin
        tape_addr  = span_low[TW-1:0];
        state_next = S_EVAL_SCAN;
      end
      S_EVAL_SCAN: begin
        tape_addr = sweep[TW-1:0] + 1'b1;
        if (!(sweep < CW'(span_high) && sweep < CW'(TapeCells)))
          state_next = S_EVAL_MAX;
      end
      S_EVAL_MAX: if (sym_i >= 9'(n_sym)) state_next = S_EVAL_MUL;
      S_EVAL_MUL: state_next = S_EVAL_CMP;
      S_EVAL_CMP: state_next = S_OUT;
      S_OUT:      if (out.ready) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else     state <= state_next;
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep      <= '0;
      head_pos   <= TW'(start_head);
      span_low   <= (TW+1)'(guard_lo);
      span_high  <= (TW+1)'(guard_hi);
      steps      <= '0;
      mstate     <= start_state;
      r_status   <= ST_DONE;
      r_keep     <= 1'b0;
      act        <= ACT_STEP;
      for (int i = 0; i < MaxSymbols; i++) counts[i] <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          act      <= in.action;
          tsym_q   <= in.tape_symbol;
          amp_q    <= in.amplitude;
          r_status <= ST_DONE;
          r_keep   <= 1'b0;
          sweep    <= '0;
        end
        S_CLEAR: begin
          sweep <= sweep + 1'b1;
          if (act == ACT_CLEAR) begin
            head_pos  <= TW'(start_head);
            span_low  <= (TW+1)'(guard_lo);
            span_high <= (TW+1)'(guard_hi);
            steps     <= '0;
            mstate    <= 6'(start_state[QW-1:0]);
          end
        end
        S_STEP_EXEC: begin
          if (act == ACT_APPEND) begin
            if (9'(tsym_q) >= 9'(n_sym)) r_status <= ST_IGNORED;
            else if ({1'b0, head_pos} >= tape_edge) r_status <= ST_EDGE;
            else begin
              head_pos  <= head_pos + 1'b1;
              span_high <= (({1'b0, head_pos} > span_high) ? {1'b0, head_pos}
                            : span_high) + 1'b1;
              if ({1'b0, head_pos} < span_low) span_low <= {1'b0, head_pos};
            end
          end else if ((steps > 12'(time_limit)) ||
                       ((TW+2)'(span_limit) < amp_now)) begin
            r_status <= ST_LIMIT;
          end else if ((head_pos == '0) || ({1'b0, head_pos} >= tape_edge)) begin
            r_status <= ST_EDGE;
          end else if (move_t'(rule_mv) == MV_HALT) begin
            r_status <= ST_HALTED;
          end else begin
            head_pos <= head_moved;
            mstate   <= 6'(rule_nxt);
            steps    <= steps + 1'b1;
            if ({1'b0, head_moved} > span_high) span_high <= {1'b0, head_moved};
            if ({1'b0, head_moved} < span_low)  span_low  <= {1'b0, head_moved};
          end
        end
        S_EVAL_CLR: begin
          for (int i = 0; i < MaxSymbols; i++) counts[i] <= '0;
          sweep <= CW'(span_low);
        end
        S_EVAL_SCAN: begin
          // Count the cell read last cycle; a read is issued for sweep+1.
          if (sweep < CW'(span_high) && sweep < CW'(TapeCells)) begin
            counts[tape_rd] <= counts[tape_rd] + 1'b1;
            sweep <= sweep + 1'b1;
          end
          best  <= '0;
          sym_i <= '0;
        end
        S_EVAL_MAX: begin
          // Symbol 0 always counts, even with no symbols in use.
          if (sym_i == '0 ||
              (sym_i < 9'(n_sym) && counts[sym_i[SW-1:0]] > best))
            best <= counts[sym_i[SW-1:0]];
          sym_i <= sym_i + 1'b1;
        end
        S_EVAL_MUL: prod <= 30'(max_share) * 30'(amp_q);
        S_EVAL_CMP: r_keep <= (30'({best, 16'd0}) > prod) ? 1'b0 : 1'b1;
        default: ;
      endcase
    end
  end

endmodule

/* dv/turing_machine_stepper_checker.sv */
`timescale 1ns / 1ps

// Watches the configuration port and both channels, keeps its own copy of the
// machine and compares every result beat with the oldest outstanding prediction.
module turing_machine_stepper_checker
  import tms_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_data,
  tms_in_if           in_ch,
  tms_out_if          out_ch,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    status_t     status;
    logic        keep_going;
    logic [5:0]  head_state;
    logic [11:0] head_position;
    logic [11:0] step_count;
    logic [11:0] tape_amplitude;
  } tm_result_t;

  tm_result_t result_q[$];

  int unsigned time_limit, span_limit, share_limit, alphabet, start_state;

  logic [3:0] rule_sym [MAX_SYMBOLS*MAX_STATES];
  move_t      rule_mv  [MAX_SYMBOLS*MAX_STATES];
  logic [5:0] rule_nxt [MAX_SYMBOLS*MAX_STATES];
  logic [3:0] tape [TAPE_CELLS];
  int unsigned head, span_lo, span_hi, step_cnt, mstate;

  function automatic int unsigned tape_limit();
    int unsigned e;
    e = 2 * time_limit + 1;
    return (e > TAPE_CELLS - 1) ? TAPE_CELLS - 1 : e;
  endfunction

  function automatic int unsigned symbols_used();
    return (alphabet < MAX_SYMBOLS) ? alphabet : MAX_SYMBOLS;
  endfunction

  function automatic void restart_tape();
    foreach (tape[i]) tape[i] = '0;
    head     = time_limit + 1;
    span_lo  = (head >= TAPE_GUARD) ? head - TAPE_GUARD : 0;
    span_hi  = head + TAPE_GUARD;
    step_cnt = 0;
    mstate   = start_state % MAX_STATES;
  endfunction

  function automatic status_t run_step();
    int unsigned idx;
    if (step_cnt > time_limit || span_limit < span_hi - span_lo + 1) return ST_LIMIT;
    if (head == 0 || head >= tape_limit()) return ST_EDGE;
    idx = tape[head] * MAX_STATES + mstate;
    tape[head] = rule_sym[idx];
    if (rule_mv[idx] == MV_HALT) return ST_HALTED;
    if (rule_mv[idx] == MV_LEFT) head--;
    else if (rule_mv[idx] == MV_RIGHT) head++;
    mstate = 32'(rule_nxt[idx]);
    if (head > span_hi) span_hi = head;
    if (head < span_lo) span_lo = head;
    step_cnt++;
    return ST_DONE;
  endfunction

  function automatic status_t run_append(logic [7:0] sym);
    if (sym >= symbols_used()) return ST_IGNORED;
    if (head >= tape_limit()) return ST_EDGE;
    if (head > span_hi) span_hi = head;
    if (head < span_lo) span_lo = head;
    span_hi++;
    head++;
    tape[head] = sym[3:0];
    return ST_DONE;
  endfunction

  // The verdict is exact: largest count * 65536 against share_limit * amplitude.
  function automatic logic run_spread(logic [12:0] amp);
    int unsigned counts[MAX_SYMBOLS];
    int unsigned best;
    foreach (counts[i]) counts[i] = 0;
    for (int unsigned x = span_lo; x < span_hi && x < TAPE_CELLS; x++)
      counts[tape[x]]++;
    best = counts[0];
    for (int unsigned s = 1; s < symbols_used(); s++)
      if (counts[s] > best) best = counts[s];
    return (longint'(best) * 65536 > longint'(share_limit) * amp) ? 1'b0 : 1'b1;
  endfunction

  function automatic tm_result_t predict_beat();
    tm_result_t r;
    int unsigned idx, amp;
    r.status     = ST_DONE;
    r.keep_going = 1'b0;
    case (in_ch.action)
      ACT_STEP: r.status = run_step();
      ACT_RULE: begin
        idx = in_ch.read_symbol * MAX_STATES + in_ch.rule_state;
        rule_sym[idx] = in_ch.write_symbol;
        rule_mv[idx]  = move_t'(in_ch.move_code);
        rule_nxt[idx] = in_ch.next_state;
      end
      ACT_APPEND: r.status = run_append(in_ch.tape_symbol);
      ACT_CLEAR:  restart_tape();
      ACT_EVAL:   r.keep_going = run_spread(in_ch.amplitude);
      default: ;
    endcase
    amp = span_hi - span_lo + 1;
    r.head_state     = mstate[5:0];
    r.head_position  = head[11:0];
    r.step_count     = step_cnt[11:0];
    r.tape_amplitude = (amp > 4095) ? 12'd4095 : amp[11:0];
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    tm_result_t want;
    if (rst) begin
      time_limit  = 1000;
      span_limit  = 4095;
      share_limit = 65536;
      alphabet    = 2;
      start_state = 0;
      restart_tape();
      result_q.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAX_TIME:  time_limit  = 32'(cfg_data[10:0]);
          CFG_MAX_AMP:   span_limit  = 32'(cfg_data[11:0]);
          CFG_MAX_SHARE: share_limit = 32'(cfg_data[16:0]);
          CFG_ALPHABET:  alphabet    = 32'(cfg_data[4:0]);
          CFG_INIT_ST:   start_state = 32'(cfg_data[5:0]);
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (result_q.size() == 0) begin
          errors++;
          $display("%0t: result beat with nothing expected, actual status %0d",
                   $time, out_ch.status);
        end else begin
          want = result_q.pop_front();
          check_field("status", 32'(want.status), 32'(out_ch.status));
          check_field("keep_going", 32'(want.keep_going), 32'(out_ch.keep_going));
          check_field("head_state", 32'(want.head_state), 32'(out_ch.head_state));
          check_field("head_position", 32'(want.head_position),
                      32'(out_ch.head_position));
          check_field("step_count", 32'(want.step_count), 32'(out_ch.step_count));
          check_field("tape_amplitude", 32'(want.tape_amplitude),
                      32'(out_ch.tape_amplitude));
        end
      end
      if (in_ch.valid && in_ch.ready) result_q.push_back(predict_beat());
    end
    pending = result_q.size();
  end

endmodule

/* dv/turing_machine_stepper_core_tb.sv */
`timescale 1ns / 1ps

// Top of the stepper testbench. It loads a rule table, then runs a series of
// register settings, each opened by a tape clear and followed by a random mix
// of beats. The checker next to the core predicts and compares every result.
module turing_machine_stepper_core_tb;
  import tms_pkg::*;

  // Action codes that the core does not define; they must change nothing.
  localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
  localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;
  // Cycles with no beat on either channel before the run is declared hung.
  localparam int IDLE_LIMIT = 20000;
  localparam int PHASE_ITEMS = 250;

  typedef struct packed {
    logic [2:0]  action;
    logic [3:0]  read_symbol;
    logic [5:0]  rule_state;
    logic [3:0]  write_symbol;
    logic [1:0]  move_code;
    logic [5:0]  next_state;
    logic [7:0]  tape_symbol;
    logic [12:0] amplitude;
  } tm_beat_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [16:0] cfg_data;

  tms_in_if  in_ch ();
  tms_out_if out_ch ();

  int errors, pending;
  int beats_sent = 0;
  int settings_run = 0;
  int idle_cycles = 0;
  int unsigned alphabet_now = 2;
  bit quiet = 1'b0;      // no idling on either side near the end of the run
  bit long_hold = 1'b0;  // asks the receiver for one long stall

  always #5 clk = ~clk;

  turing_machine_stepper_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in        (in_ch),
    .out       (out_ch)
  );

  turing_machine_stepper_checker state_check (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .errors    (errors),
    .pending   (pending)
  );

  // The watchdog restarts on every accepted beat. Long clears and spread
  // evaluations stay well inside the limit.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no beat for %0d cycles", IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result receiver. It stalls in short random bursts, and once on request
  // for a long stretch so that the core fills up and holds off its input.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
        long_hold = 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Offers one beat and returns at the edge where it was accepted. A random
  // gap may come first; valid is lowered and raised in different steps.
  task automatic send(input tm_beat_t b);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.action       <= b.action;
    in_ch.read_symbol  <= b.read_symbol;
    in_ch.rule_state   <= b.rule_state;
    in_ch.write_symbol <= b.write_symbol;
    in_ch.move_code    <= b.move_code;
    in_ch.next_state   <= b.next_state;
    in_ch.tape_symbol  <= b.tape_symbol;
    in_ch.amplitude    <= b.amplitude;
    do @(posedge clk); while (!in_ch.ready);
    beats_sent++;
  endtask

  // Next states are kept within the set whose rules were all loaded, so a
  // step never reads a rule entry that was never written.
  function automatic logic [5:0] loaded_state();
    int unsigned k;
    k = $urandom_range(0, 8);
    return (k == 8) ? 6'd63 : k[5:0];
  endfunction

  function automatic logic [1:0] pick_move();
    int unsigned k;
    k = $urandom_range(0, 9);
    if (k < 4) return MV_LEFT;
    if (k < 8) return MV_RIGHT;
    if (k == 8) return MV_STAY;
    return MV_HALT;
  endfunction

  // Every field carries random content, whichever action is chosen.
  function automatic tm_beat_t random_beat();
    tm_beat_t b;
    int unsigned w;
    b.read_symbol  = 4'($urandom_range(0, 15));
    b.rule_state   = 6'($urandom_range(0, 63));
    b.write_symbol = 4'($urandom_range(0, 15));
    b.move_code    = pick_move();
    b.next_state   = loaded_state();
    if ($urandom_range(0, 4) != 0) b.tape_symbol = 8'($urandom_range(0, alphabet_now - 1));
    else b.tape_symbol = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 5) != 0) b.amplitude = 13'($urandom_range(1, 4096));
    else b.amplitude = 13'($urandom_range(0, 8191));
    w = $urandom_range(0, 99);
    if (w < 45) b.action = ACT_STEP;
    else if (w < 58) b.action = ACT_RULE;
    else if (w < 78) b.action = ACT_APPEND;
    else if (w < 80) b.action = ACT_CLEAR;
    else if (w < 90) b.action = ACT_EVAL;
    else if (w < 93) b.action = 3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
    else b.action = ACT_STEP;
    return b;
  endfunction

  function automatic tm_beat_t with_action(logic [2:0] act);
    tm_beat_t b;
    b = random_beat();
    b.action = act;
    return b;
  endfunction

  // The first edge lets the checker count a beat accepted just before.
  task automatic wait_drained();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Registers are written back to back while the core is idle; the write
  // enable is lowered once after the last one.
  task automatic write_settings(input int unsigned t, a, s, al, st);
    int unsigned vals[5];
    vals = '{t, a, s, al, st};
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= cfg_index_t'(i);
      cfg_data  <= 17'(vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    alphabet_now = (al == 0) ? 1 : al;
    settings_run++;
  endtask

  // One register setting: apply it, restart the tape so that the new step
  // limit takes effect, then a stretch of random beats. Valid is dropped
  // first so that the last beat is not offered again while the core drains.
  task automatic run_setting(input int unsigned t, a, s, al, st, input bit last_one);
    in_ch.valid <= 1'b0;
    wait_drained();
    @(posedge clk);
    write_settings(t, a, s, al, st);
    send(with_action(ACT_CLEAR));
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (settings_run == 2 && i == 10) long_hold = 1'b1;
      if (last_one && i == PHASE_ITEMS / 2) quiet = 1'b1;
      send(random_beat());
    end
  endtask

  initial begin
    tm_beat_t b;
    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_index    <= CFG_MAX_TIME;
    cfg_data     <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.action <= ACT_STEP;
    in_ch.read_symbol  <= '0;
    in_ch.rule_state   <= '0;
    in_ch.write_symbol <= '0;
    in_ch.move_code    <= MV_LEFT;
    in_ch.next_state   <= '0;
    in_ch.tape_symbol  <= '0;
    in_ch.amplitude    <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Load a rule for every symbol in every state the machine can reach.
    for (int sym = 0; sym < MAX_SYMBOLS; sym++) begin
      for (int k = 0; k < 9; k++) begin
        b = with_action(ACT_RULE);
        b.read_symbol = 4'(sym);
        b.rule_state  = (k == 8) ? 6'd63 : 6'(k);
        b.move_code   = (sym % 3 == 0) ? MV_LEFT : (sym % 3 == 1) ? MV_RIGHT : MV_STAY;
        send(b);
      end
    end

    // Directed beats under the reset settings: symbols at the alphabet's
    // border and beyond it, plain steps, the evaluate extremes and the
    // undefined action codes.
    b = with_action(ACT_APPEND); b.tape_symbol = 8'd0;   send(b);
    b = with_action(ACT_APPEND); b.tape_symbol = 8'd1;   send(b);
    b = with_action(ACT_APPEND); b.tape_symbol = 8'd2;   send(b);
    b = with_action(ACT_APPEND); b.tape_symbol = 8'd15;  send(b);
    b = with_action(ACT_APPEND); b.tape_symbol = 8'd255; send(b);
    repeat (4) send(with_action(ACT_STEP));
    b = with_action(ACT_EVAL); b.amplitude = 13'd0;    send(b);
    b = with_action(ACT_EVAL); b.amplitude = 13'd1;    send(b);
    b = with_action(ACT_EVAL); b.amplitude = 13'd4096; send(b);
    b = with_action(ACT_EVAL); b.amplitude = 13'd8191; send(b);
    // After a clear the tape holds symbol 0 under the head in state 0, so a halt
    // is forced by pointing the rule for symbol 0 in state 0 at a halt.
    b = with_action(ACT_RULE);
    b.read_symbol = 4'd0; b.rule_state = 6'd0; b.move_code = MV_HALT;
    b.next_state = 6'd0;
    send(b);
    send(with_action(ACT_CLEAR));
    send(with_action(ACT_STEP));
    send(with_action(ACT_STEP));
    send(with_action(ACT_SPARE_FIRST));
    send(with_action(3'd6));
    send(with_action(ACT_SPARE_LAST));

    run_setting(1000, 4095, 65536, 2, 0, 1'b0);
    run_setting(1, 1, 0, 1, 63, 1'b0);
    run_setting(2000, 4095, 65536, 16, 7, 1'b0);
    run_setting(5, 40, 32768, 4, 3, 1'b0);
    run_setting(30, 4095, 20000, 16, 63, 1'b0);
    run_setting(2000, 100, 50000, 9, 1, 1'b1);

    in_ch.valid <= 1'b0;
    wait_drained();
    repeat (50) @(posedge clk);

    $display("Covered %0d beats over %0d register settings: steps, rule writes,",
             beats_sent, settings_run);
    $display("appends, tape clears, spread checks and undefined action codes.");
    if (errors == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* turing_machine_stepper_core.f */
rtl/core/tms_pkg.sv
rtl/core/tms_if.sv
rtl/core/turing_machine_stepper_core.sv
dv/turing_machine_stepper_checker.sv
dv/turing_machine_stepper_core_tb.sv
